/* rtl/core/dcb_pkg.sv */
// ----------------------------------------------------------------------------
// DC blocker package
// Shared widths, fixed-point constants and register map of the DC blocker.
// ----------------------------------------------------------------------------
package dcb_pkg;

    // Default configuration handed to the top level.
    localparam int DEF_CHANNELS      = 4;
    localparam int DEF_FRACTION_BITS = 16;

    // Field widths.
    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int INT_BITS = 18;

    // Offset of the converter code and limits of the send value.
    localparam logic [INT_BITS-1:0] SAMPLE_OFFSET = 18'd32768;
    localparam logic [SAMPLE_W-1:0] SEND_MAX      = 16'd65535;

    // The coefficient 0.9999 in Q1.23 is 2^23 - 839. Scaling by it is done as
    // v - ceil((v * 839 - 2^22) / 2^23), which equals round-half-up of v * A.
    localparam int COEF_SHIFT     = 23;
    localparam int DEFICIT_W      = 10;
    localparam int COEF_DEFICIT   = 839;
    localparam int ROUND_BIAS     = (1 << (COEF_SHIFT - 1)) - 1;

    // Register map (index is byte address divided by four).
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_DC_CUT_ENABLE = 1'b0;

endpackage

/* rtl/core/dcb_apb_regs.sv */
// ----------------------------------------------------------------------------
// DC blocker register file
// APB-style slave holding the DC-cut enable bit.
// ----------------------------------------------------------------------------
module dcb_apb_regs
    import dcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_dc_cut_enable
);

    logic       r_dc_cut_enable;
    logic [0:0] reg_idx;
    logic       wr_req;

    // Word index and write strobe of the access phase.
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_req  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Enable register; writes to other addresses are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_cut_enable <= 1'b0;
        end else if (wr_req && reg_idx == REG_DC_CUT_ENABLE) begin
            r_dc_cut_enable <= pwdata[0];
        end
    end

    // Read data path.
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_DC_CUT_ENABLE) begin
            prdata = {{(CFG_DATA_W-1){1'b0}}, r_dc_cut_enable};
        end
    end

    assign o_dc_cut_enable = r_dc_cut_enable;

endmodule

/* rtl/core/dcb_history.sv */
// ----------------------------------------------------------------------------
// DC blocker channel history
// Per-channel previous input and output, with valid bits and write forwarding.
// ----------------------------------------------------------------------------
module dcb_history
    import dcb_pkg::*;
#(
    parameter int CHANNELS      = DEF_CHANNELS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_rd_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_rd_idx,
    input  logic                                        i_wr_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_wr_idx,
    input  logic signed [INT_BITS-1:0]                  i_wr_x,
    input  logic signed [INT_BITS+FRACTION_BITS-1:0]    i_wr_y,
    output logic signed [INT_BITS-1:0]                  o_prev_x,
    output logic signed [INT_BITS+FRACTION_BITS-1:0]    o_prev_y
);

    localparam int SW = INT_BITS + FRACTION_BITS;

    logic signed [INT_BITS-1:0] mem_x [CHANNELS];
    logic signed [SW-1:0]       mem_y [CHANNELS];
    logic [CHANNELS-1:0]        r_vld;
    logic signed [INT_BITS-1:0] r_rd_x;
    logic signed [SW-1:0]       r_rd_y;
    logic                       r_rd_vld;
    logic                       r_fwd;
    logic signed [INT_BITS-1:0] r_fwd_x;
    logic signed [SW-1:0]       r_fwd_y;

    // History memories with registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_x[i_wr_idx] <= i_wr_x;
            mem_y[i_wr_idx] <= i_wr_y;
        end
        if (i_rd_en) begin
            r_rd_x <= mem_x[i_rd_idx];
            r_rd_y <= mem_y[i_rd_idx];
        end
    end

    // Valid bits: an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
                r_fwd    <= i_wr_en && (i_wr_idx == i_rd_idx);
            end
        end
    end

    // Capture the value written in the same cycle as a read of that channel.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_x <= i_wr_x;
            r_fwd_y <= i_wr_y;
        end
    end

    // Select forwarded, stored or reset value.
    always_comb begin
        if (r_fwd) begin
            o_prev_x = r_fwd_x;
            o_prev_y = r_fwd_y;
        end else if (r_rd_vld) begin
            o_prev_x = r_rd_x;
            o_prev_y = r_rd_y;
        end else begin
            o_prev_x = '0;
            o_prev_y = '0;
        end
    end

endmodule

/* rtl/core/dcb_filter_core.sv */
// ----------------------------------------------------------------------------
// DC blocker arithmetic
// One filter step: y = x - x_prev + A * y_prev, saturation and output coding,
// or pass-through of the sample when the DC cut is disabled.
module dcb_filter_core
    import dcb_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                                     i_dc_cut_enable,
    input  logic [SAMPLE_W-1:0]                      i_sample,
    input  logic signed [INT_BITS-1:0]               i_prev_x,
    input  logic signed [INT_BITS+FRACTION_BITS-1:0] i_prev_y,
    output logic signed [INT_BITS-1:0]               o_filtered,
    output logic [SAMPLE_W-1:0]                      o_send_value,
    output logic signed [INT_BITS-1:0]               o_new_x,
    output logic signed [INT_BITS+FRACTION_BITS-1:0] o_new_y
);

    localparam int SW = INT_BITS + FRACTION_BITS;
    localparam int PW = SW + DEFICIT_W;
    localparam int YW = SW + 2;
    localparam logic signed [YW-1:0] Y_MAX = YW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] Y_MIN = YW'(-(64'sd1 <<< (SW - 1)));

    logic signed [INT_BITS-1:0] x;
    logic [SW-1:0]              mag;
    logic [PW-1:0]              prod;
    logic [PW-1:0]              rnd;
    logic [SW-1:0]              scaled_mag;
    logic signed [INT_BITS:0]   diff;
    logic signed [YW-1:0]       term;
    logic signed [YW-1:0]       scaled;
    logic signed [YW-1:0]       sum;
    logic signed [SW-1:0]       y_sat;
    logic signed [INT_BITS-1:0] fl;
    logic signed [INT_BITS:0]   send_s;
    logic [SAMPLE_W-1:0]        send_clamped;

    // Centered sample.
    assign x = signed'({2'b00, i_sample} - SAMPLE_OFFSET);

    // A * |y_prev| rounded half up, using the small coefficient deficit.
    assign mag        = i_prev_y[SW-1] ? SW'(-i_prev_y) : SW'(i_prev_y);
    assign prod       = PW'(mag) * PW'(COEF_DEFICIT);
    assign rnd        = prod + PW'(ROUND_BIAS);
    assign scaled_mag = mag - SW'(rnd >> COEF_SHIFT);
    assign scaled     = i_prev_y[SW-1] ? -signed'({2'b00, scaled_mag})
                                       : signed'({2'b00, scaled_mag});

    // Input difference moved to the fixed-point grid and added.
    assign diff = {x[INT_BITS-1], x} - {i_prev_x[INT_BITS-1], i_prev_x};
    assign term = {diff[INT_BITS], diff, {FRACTION_BITS{1'b0}}};
    assign sum  = term + scaled;

    // Saturate to 18 integer bits.
    always_comb begin
        if (sum > Y_MAX) begin
            y_sat = SW'(Y_MAX);
        end else if (sum < Y_MIN) begin
            y_sat = SW'(Y_MIN);
        end else begin
            y_sat = SW'(sum);
        end
    end

    // Integer part by floor and the clamped offset-binary send value.
    assign fl     = y_sat[SW-1:FRACTION_BITS];
    assign send_s = {fl[INT_BITS-1], fl} + signed'({1'b0, SAMPLE_OFFSET});

    always_comb begin
        if (send_s < 0) begin
            send_clamped = '0;
        end else if (send_s > signed'({3'b000, SEND_MAX})) begin
            send_clamped = SEND_MAX;
        end else begin
            send_clamped = send_s[SAMPLE_W-1:0];
        end
    end

    // Filter or pass-through selection.
    always_comb begin
        if (i_dc_cut_enable) begin
            o_filtered   = fl;
            o_send_value = send_clamped;
            o_new_x      = x;
            o_new_y      = y_sat;
        end else begin
            o_filtered   = x;
            o_send_value = i_sample;
            o_new_x      = x;
            o_new_y      = {x, {FRACTION_BITS{1'b0}}};
        end
    end

endmodule

/* rtl/core/dc_blocking_highpass_filter_unit.sv */
// ----------------------------------------------------------------------------
// DC blocking high-pass filter unit
// Per-channel first-order DC blocker on offset-binary converter samples.
// ----------------------------------------------------------------------------
// Path: an accepted request waits in the input register and is loaded into the
// result register, raising o_valid, when that register is free or being read.
// Throughput: one request per cycle unless i_ready stalls; the channel history
// is read and written once per cycle, the in-flight write forwarded to the read.
// Reset: synchronous, active low; clears the enable bit and the history valid
// bits, so every channel history reads as zero until written.
// ----------------------------------------------------------------------------
module dc_blocking_highpass_filter_unit
    import dcb_pkg::*;
#(
    parameter int CHANNELS      = DEF_CHANNELS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_ADDR_W-1:0]      paddr,
    input  logic [CFG_DATA_W-1:0]      pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [CHAN_W-1:0]          i_channel,
    input  logic [SAMPLE_W-1:0]        i_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [CHAN_W-1:0]          o_channel_out,
    output logic signed [INT_BITS-1:0] o_filtered,
    output logic [SAMPLE_W-1:0]        o_send_value
);

    localparam int SW   = INT_BITS + FRACTION_BITS;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                       dc_cut_enable;
    logic                       accept;
    logic                       advance;
    logic                       in_ch_ok;
    logic                       r_in_valid;
    logic [CHAN_W-1:0]          r_in_ch;
    logic [SAMPLE_W-1:0]        r_in_sample;
    logic                       r_in_ch_ok;
    logic                       r_out_valid;
    logic [CHAN_W-1:0]          r_out_ch;
    logic signed [INT_BITS-1:0] r_out_filt;
    logic [SAMPLE_W-1:0]        r_out_send;
    logic signed [INT_BITS-1:0] hist_x;
    logic signed [SW-1:0]       hist_y;
    logic signed [INT_BITS-1:0] prev_x;
    logic signed [SW-1:0]       prev_y;
    logic signed [INT_BITS-1:0] core_filt;
    logic [SAMPLE_W-1:0]        core_send;
    logic signed [INT_BITS-1:0] new_x;
    logic signed [SW-1:0]       new_y;

    // Configuration registers.
    dcb_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_dc_cut_enable (dc_cut_enable)
    );

    // Handshake: the compute stage moves when the result register is free.
    assign advance  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || advance;
    assign accept   = i_valid && o_ready;
    assign in_ch_ok = 32'(i_channel) < CHANNELS;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_ch     <= i_channel;
            r_in_sample <= i_sample;
            r_in_ch_ok  <= in_ch_ok;
        end
    end

    // Channel history, read on accept and written when the result is formed.
    dcb_history #(
        .CHANNELS      (CHANNELS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept && in_ch_ok),
        .i_rd_idx (CH_W'(i_channel)),
        .i_wr_en  (advance && r_in_ch_ok),
        .i_wr_idx (CH_W'(r_in_ch)),
        .i_wr_x   (new_x),
        .i_wr_y   (new_y),
        .o_prev_x (hist_x),
        .o_prev_y (hist_y)
    );

    // A channel outside the configured range sees a zero history.
    assign prev_x = r_in_ch_ok ? hist_x : '0;
    assign prev_y = r_in_ch_ok ? hist_y : '0;

    // Filter arithmetic.
    dcb_filter_core #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .i_dc_cut_enable (dc_cut_enable),
        .i_sample        (r_in_sample),
        .i_prev_x        (prev_x),
        .i_prev_y        (prev_y),
        .o_filtered      (core_filt),
        .o_send_value    (core_send),
        .o_new_x         (new_x),
        .o_new_y         (new_y)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_ch   <= r_in_ch;
            r_out_filt <= core_filt;
            r_out_send <= core_send;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_filtered    = r_out_filt;
    assign o_send_value  = r_out_send;

    // Within the 16-bit range the send value is the filtered value re-offset.
    a_send_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_filtered >= -18'sd32768 && o_filtered <= 18'sd32767)
        |-> (o_send_value == 16'(o_filtered + 18'sd32768)))
        else $error("send value does not match filtered value");

    // A full pipeline with a stalled result takes no new request.
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("request accepted while pipeline is full");

    // A new result only appears when the input stage held a request.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a request");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DC blocker testbench
// Drives sample requests into the DC blocking high-pass filter unit under
// random gaps and back-pressure. It predicts every result from its own
// per-channel history and compares the channel, the filtered value and the
// send value of each returned result in order.
// ----------------------------------------------------------------------------
module testbench;
    import dcb_pkg::*;

    // Fixed-point view of the filter history.
    localparam int     FRAC        = DEF_FRACTION_BITS;
    localparam longint STATE_ONE   = 64'sd1 <<< FRAC;
    localparam longint Y_MAX       = (64'sd1 <<< (INT_BITS - 1 + FRAC)) - 1;
    localparam longint Y_MIN       = -(64'sd1 <<< (INT_BITS - 1 + FRAC));
    // 0.9999 in Q1.23, rounded to nearest.
    localparam longint DC_COEF_Q23 = 64'sd8387769;
    localparam int     COEF_FRAC   = 23;
    localparam longint COEF_HALF   = 64'sd1 <<< (COEF_FRAC - 1);
    localparam longint ZERO_CODE   = 64'sd32768;
    localparam longint SEND_TOP    = 64'sd65535;

    // Register byte addresses.
    localparam logic [CFG_ADDR_W-1:0] ADDR_DC_CUT = {REG_DC_CUT_ENABLE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    // Run control.
    localparam int DUT_LATENCY = 2;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_LIMIT = 200000;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] smp;
    } sample_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          chan;
        logic signed [INT_BITS-1:0] filt;
        logic [SAMPLE_W-1:0]        send;
    } filter_result_t;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0]      paddr     = '0;
    logic [CFG_DATA_W-1:0]      pwdata    = '0;
    logic [CFG_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       i_valid   = 1'b0;
    logic                       o_ready;
    logic [CHAN_W-1:0]          i_channel = '0;
    logic [SAMPLE_W-1:0]        i_sample  = '0;
    logic                       o_valid;
    logic                       i_ready   = 1'b0;
    logic [CHAN_W-1:0]          o_channel_out;
    logic signed [INT_BITS-1:0] o_filtered;
    logic [SAMPLE_W-1:0]        o_send_value;

    // Pending sample requests and predicted filter outputs.
    sample_req_t    sample_q[$];
    filter_result_t filter_results_q[$];

    // Predictor state: enable bit and per-channel history.
    bit     cut_en = 1'b0;
    longint hist_in[DEF_CHANNELS];
    longint hist_out[DEF_CHANNELS];

    // Idling control, set per phase by the sequence.
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int send_gap      = 0;
    int hold_cnt      = 0;
    int mismatches    = 0;
    int dc_base[DEF_CHANNELS];

    dc_blocking_highpass_filter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_channel_out (o_channel_out),
        .o_filtered    (o_filtered),
        .o_send_value  (o_send_value)
    );

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Global guard against a hung run.
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Compute one filter step and update the channel history.
    function automatic filter_result_t dc_block_step(input logic [CHAN_W-1:0] ch,
                                                     input logic [SAMPLE_W-1:0] smp);
        filter_result_t res;
        longint x, xp, yp, mag, scaled, y, fl, send;
        bit     known;
        known = (ch < DEF_CHANNELS);
        x = longint'(smp) - ZERO_CODE;
        if (cut_en) begin
            xp = known ? hist_in[ch] : 0;
            yp = known ? hist_out[ch] : 0;
            // Scale the magnitude so the rounding is symmetric about zero.
            mag = (yp < 0) ? -yp : yp;
            scaled = (mag * DC_COEF_Q23 + COEF_HALF) >>> COEF_FRAC;
            if (yp < 0) scaled = -scaled;
            y = (x - xp) * STATE_ONE + scaled;
            if (y > Y_MAX) y = Y_MAX;
            if (y < Y_MIN) y = Y_MIN;
            fl = y >>> FRAC;
            send = fl + ZERO_CODE;
            if (send < 0) send = 0;
            if (send > SEND_TOP) send = SEND_TOP;
            if (known) begin
                hist_in[ch] = x;
                hist_out[ch] = y;
            end
        end else begin
            fl = x;
            send = longint'(smp);
            if (known) begin
                hist_in[ch] = x;
                hist_out[ch] = x * STATE_ONE;
            end
        end
        res.chan = ch;
        res.filt = fl[INT_BITS-1:0];
        res.send = send[SAMPLE_W-1:0];
        return res;
    endfunction

    // Sender: presents queued requests, predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                filter_results_q.push_back(dc_block_step(i_channel, i_sample));
                void'(sample_q.pop_front());
            end
            if (i_valid && !o_ready) begin
                // Hold the request until it is taken.
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                i_valid   <= 1'b1;
                i_channel <= sample_q[0].chan;
                i_sample  <= sample_q[0].smp;
                send_gap = send_idle_on ? pick_gap() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Compare one returned result with the oldest prediction.
    task automatic check_result();
        filter_result_t want;
        if (filter_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result ch=%0d filtered=%0d send=%0d",
                                      o_channel_out, o_filtered, o_send_value));
            return;
        end
        want = filter_results_q.pop_front();
        if (o_channel_out !== want.chan)
            report_mismatch($sformatf("channel %0d, predicted %0d", o_channel_out, want.chan));
        if (o_filtered !== want.filt)
            report_mismatch($sformatf("ch %0d filtered %0d, predicted %0d",
                                      want.chan, o_filtered, want.filt));
        if (o_send_value !== want.send)
            report_mismatch($sformatf("ch %0d send value %0d, predicted %0d",
                                      want.chan, o_send_value, want.send));
    endtask

    // Receiver: checks results and throttles ready, including long holds.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (o_valid && i_ready) check_result();
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_cnt = LONG_HOLD;
            end else if (hold_cnt == 0 && recv_idle_on && $urandom_range(99) < 30) begin
                hold_cnt = pick_gap();
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic queue_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        sample_req_t req;
        req.chan = ch;
        req.smp  = smp;
        sample_q.push_back(req);
    endtask

    // Mix of DC with noise, full-range values, extremes and level steps.
    function automatic logic [SAMPLE_W-1:0] next_sample(input int ch);
        int r, v;
        r = $urandom_range(99);
        if (r < 45) begin
            v = dc_base[ch] + $urandom_range(512) - 256;
        end else if (r < 80) begin
            v = $urandom_range(65535);
        end else if (r < 90) begin
            case ($urandom_range(3))
                0:       v = 0;
                1:       v = 65535;
                2:       v = 32768;
                default: v = 32767;
            endcase
        end else begin
            dc_base[ch] = $urandom_range(1) ? $urandom_range(65535, 60000)
                                            : $urandom_range(5535);
            v = dc_base[ch];
        end
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic queue_random(input int count);
        int k, ch;
        for (k = 0; k < count; k++) begin
            ch = $urandom_range(DEF_CHANNELS - 1);
            queue_sample(ch[CHAN_W-1:0], next_sample(ch));
        end
    endtask

    // Register write; the predictor takes the new value at the same time.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[CFG_ADDR_W-1:2] == REG_DC_CUT_ENABLE) cut_en = data[0];
    endtask

    // Register read, sampled in the middle of the access cycle.
    task automatic cfg_read(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== want)
            report_mismatch($sformatf("register at %0d reads %0h, predicted %0h",
                                      addr, prdata, want));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued request has come back, then let the pipe settle.
    task automatic drain_results();
        int waited;
        waited = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while ((sample_q.size() != 0 || i_valid || filter_results_q.size() != 0)
                   && waited < DRAIN_LIMIT);
        if (waited >= DRAIN_LIMIT)
            report_mismatch($sformatf("%0d results never returned", filter_results_q.size()));
        repeat (DUT_LATENCY + 2) @(posedge i_clk);
    endtask

    // Test sequence.
    initial begin
        int ch;
        for (ch = 0; ch < DEF_CHANNELS; ch++) begin
            hist_in[ch]  = 0;
            hist_out[ch] = 0;
            dc_base[ch]  = $urandom_range(65535);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bypass after reset: extremes and mid-scale codes pass unchanged.
        cfg_read(ADDR_DC_CUT, 32'd0);
        queue_sample(2'd0, 16'h0000);
        queue_sample(2'd1, 16'h0000);
        queue_sample(2'd2, 16'hFFFF);
        queue_sample(2'd3, 16'h7FFF);
        queue_sample(2'd0, 16'h8000);
        queue_sample(2'd0, 16'h0000);
        drain_results();

        // Filter on: steps that clamp the send value high and low, and small
        // changes that leave a fraction on both sides of zero.
        cfg_write(ADDR_DC_CUT, 32'd1);
        cfg_read(ADDR_DC_CUT, 32'd1);
        queue_sample(2'd1, 16'hFFFF);
        queue_sample(2'd2, 16'h0000);
        queue_sample(2'd3, 16'h8000);
        queue_sample(2'd3, 16'h7FFF);
        queue_sample(2'd1, 16'h0000);
        queue_sample(2'd2, 16'hFFFF);
        repeat (4) queue_sample(2'd0, 16'h0000);
        queue_sample(2'd0, 16'h8001);
        drain_results();

        // A write beyond the register list must leave the filter enabled.
        cfg_write(ADDR_UNUSED, 32'd0);
        cfg_read(ADDR_DC_CUT, 32'd1);
        queue_sample(2'd3, 16'hFFFF);
        queue_sample(2'd3, 16'h8000);
        drain_results();

        // Filter, sender at full rate against a long receiver hold.
        send_idle_on = 1'b0;
        hold_requests++;
        queue_random(350);
        drain_results();

        // Bypass with no idling on either side.
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        cfg_write(ADDR_DC_CUT, 32'hFFFF_FFFE);
        queue_random(150);
        drain_results();

        // Filter again from bypass-loaded history, idling on both sides.
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        cfg_write(ADDR_DC_CUT, 32'hFFFF_FFFF);
        queue_random(450);
        drain_results();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
